### src/msld_pkg.sv
package msld_pkg;

  localparam int TGT_W = 8;
  localparam int MV_W = 15;
  localparam int STEP_W = 8;
  localparam int LVL_W = 12;
  localparam int CMP_W = 11;
  localparam int QUO_W = 11;
  localparam int DVD_W = QUO_W + MV_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam logic [STEP_W-1:0] SLEW_RESET = 8'd20;
  localparam logic [MV_W-1:0] VLIMIT_RESET = 15'd7400;

  typedef enum logic [0:0] {
    CFG_SLEW_STEP = 1'b0,
    CFG_VOLTAGE_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_SLEW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [TGT_W-1:0] left_target;
    logic signed [TGT_W-1:0] right_target;
    logic [MV_W-1:0] supply_mv;
  } in_item_t;

  typedef struct packed {
    logic signed [LVL_W-1:0] left_drive;
    logic signed [LVL_W-1:0] right_drive;
    logic [CMP_W-1:0] left_fwd_compare;
    logic [CMP_W-1:0] left_rev_compare;
    logic [CMP_W-1:0] right_fwd_compare;
    logic [CMP_W-1:0] right_rev_compare;
  } out_item_t;

endpackage

### src/msld_div.sv
module msld_div
  import msld_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [MV_W-1:0] divisor,
  output logic done,
  output logic [QUO_W-1:0] quotient
);

  logic [MV_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r;
  logic done_r;
  logic [MV_W:0] trial;
  logic [MV_W:0] diff;
  logic ge;

  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign ge = trial >= {1'b0, divisor};
  assign diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DVD_W-1:QUO_W];
      quo_r <= dividend[QUO_W-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[MV_W-1:0] : trial[MV_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

### src/msld_slew.sv
module msld_slew
  import msld_pkg::*;
(
  input  logic signed [LVL_W-1:0] level,
  input  logic signed [LVL_W-1:0] goal,
  input  logic [STEP_W-1:0] step,
  output logic signed [LVL_W-1:0] level_nxt
);

  logic signed [LVL_W:0] lvl_ext;
  logic signed [LVL_W:0] goal_ext;
  logic signed [LVL_W:0] step_ext;
  logic signed [LVL_W:0] hi;
  logic signed [LVL_W:0] lo;
  logic signed [LVL_W:0] sel;

  assign lvl_ext = {level[LVL_W-1], level};
  assign goal_ext = {goal[LVL_W-1], goal};
  assign step_ext = signed'({{(LVL_W + 1 - STEP_W){1'b0}}, step});
  assign hi = lvl_ext + step_ext;
  assign lo = lvl_ext - step_ext;

  always_comb begin
    priority if (goal_ext > hi) begin
      sel = hi;
    end else if (goal_ext < lo) begin
      sel = lo;
    end else begin
      sel = goal_ext;
    end
  end

  assign level_nxt = sel[LVL_W-1:0];

endmodule

### src/motor_slew_limited_pwm_drive_unit.sv
// Slew-limited two-motor PWM drive.
//
// The input channel (in_valid, in_ready, in_data) takes one control tick item
// with signed left and right speed targets and the supply voltage in mV. The
// result channel (out_valid, out_ready, out_data) returns one item per tick
// with the new drive levels and the four H-bridge compare values.
// The configuration port writes the slew step (index 0) or the voltage limit
// (index 1) at any edge with cfg_we high.
// The two sides are handled one after the other through a single multiplier
// and a restoring divider that produces one quotient bit per cycle. A side
// above the voltage limit passes through the multiply, start, divide and
// slew steps; a side at or below it skips the divide. in_ready returns in
// the same cycle that the result becomes valid on the output.
// The block takes no new item until the result is loaded into the output
// register, so a new item can be accepted while a result still waits.
// When the receiver stalls, the finished result is held in the sequencer until
// the output register is free, which adds the stall to the item's cycles.
// Reset clears both drive levels to zero, restores the register defaults and
// empties the output register.
module motor_slew_limited_pwm_drive_unit
  import msld_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_item_t out_data,
  input  logic cfg_we,
  input  cfg_idx_t cfg_index,
  input  logic [MV_W-1:0] cfg_wdata
);

  state_t st_r, st_nxt;
  logic side_r;
  logic signed [TGT_W-1:0] lt_r, rt_r;
  logic [MV_W-1:0] mv_r;
  logic [DVD_W-1:0] prod_r;
  logic neg_r;
  logic scale_r;
  logic signed [LVL_W-1:0] goal_r;
  logic signed [LVL_W-1:0] left_lvl_r, right_lvl_r;
  logic [STEP_W-1:0] slew_r;
  logic [MV_W-1:0] vlim_r;
  out_item_t out_r;
  logic out_valid_r;

  logic signed [TGT_W-1:0] tgt;
  logic signed [LVL_W-1:0] tgt_ext;
  logic signed [LVL_W-1:0] goal_raw;
  logic signed [LVL_W-1:0] goal_neg;
  logic [QUO_W-1:0] mag;
  logic signed [LVL_W-1:0] cur_lvl;
  logic signed [LVL_W-1:0] new_lvl;
  logic div_start;
  logic div_done;
  logic [QUO_W-1:0] quo;
  logic signed [LVL_W-1:0] quo_ext;
  logic load_out;
  logic signed [LVL_W-1:0] left_neg, right_neg;

  assign tgt = side_r ? rt_r : lt_r;
  assign tgt_ext = LVL_W'(tgt);
  assign goal_raw = (tgt_ext <<< 3) + (tgt_ext <<< 1);
  assign goal_neg = -goal_raw;
  assign mag = goal_raw[LVL_W-1] ? goal_neg[QUO_W-1:0] : goal_raw[QUO_W-1:0];
  assign cur_lvl = side_r ? right_lvl_r : left_lvl_r;
  assign quo_ext = signed'({1'b0, quo});

  msld_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .dividend(prod_r),
    .divisor(mv_r),
    .done(div_done),
    .quotient(quo)
  );

  msld_slew u_slew (
    .level(cur_lvl),
    .goal(goal_r),
    .step(slew_r),
    .level_nxt(new_lvl)
  );

  always_comb begin
    st_nxt = st_r;
    div_start = 1'b0;
    load_out = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        st_nxt = ST_START;
      end
      ST_START: begin
        if (scale_r) begin
          div_start = 1'b1;
          st_nxt = ST_DIV;
        end else begin
          st_nxt = ST_SLEW;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          st_nxt = ST_SLEW;
        end
      end
      ST_SLEW: begin
        st_nxt = side_r ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= 1'b0;
      left_lvl_r <= '0;
      right_lvl_r <= '0;
      slew_r <= SLEW_RESET;
      vlim_r <= VLIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLEW_STEP: slew_r <= cfg_wdata[STEP_W-1:0];
          CFG_VOLTAGE_LIMIT: vlim_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (st_r == ST_IDLE && in_valid) begin
        side_r <= 1'b0;
      end else if (st_r == ST_SLEW) begin
        side_r <= ~side_r;
        if (side_r) begin
          right_lvl_r <= new_lvl;
        end else begin
          left_lvl_r <= new_lvl;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign left_neg = -left_lvl_r;
  assign right_neg = -right_lvl_r;

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_valid) begin
      lt_r <= in_data.left_target;
      rt_r <= in_data.right_target;
      mv_r <= in_data.supply_mv;
    end
    if (st_r == ST_MUL) begin
      prod_r <= DVD_W'(mag) * DVD_W'(vlim_r);
      neg_r <= goal_raw[LVL_W-1];
      scale_r <= vlim_r < mv_r;
      goal_r <= goal_raw;
    end
    if (st_r == ST_DIV && div_done) begin
      goal_r <= neg_r ? -quo_ext : quo_ext;
    end
    if (load_out) begin
      out_r.left_drive <= left_lvl_r;
      out_r.right_drive <= right_lvl_r;
      if (left_lvl_r > 0) begin
        out_r.left_fwd_compare <= left_lvl_r[CMP_W-1:0];
        out_r.left_rev_compare <= '0;
      end else begin
        out_r.left_fwd_compare <= '0;
        out_r.left_rev_compare <= left_neg[CMP_W-1:0];
      end
      if (right_lvl_r > 0) begin
        out_r.right_fwd_compare <= right_lvl_r[CMP_W-1:0];
        out_r.right_rev_compare <= '0;
      end else begin
        out_r.right_fwd_compare <= '0;
        out_r.right_rev_compare <= right_neg[CMP_W-1:0];
      end
    end
  end

  assign in_ready = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (left_lvl_r >= -12'sd1280) && (left_lvl_r <= 12'sd1270) &&
    (right_lvl_r >= -12'sd1280) && (right_lvl_r <= 12'sd1270))
    else $error("drive level left its range");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_DIV))
    else $error("divider finished outside the divide step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while the previous one is still in work");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

endmodule
